// ===== src/spq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and defaults for the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int QUEUE_DEPTH_DEF   = 16;
	localparam int PAYLOAD_BITS_DEF  = 16;
	localparam int PRIORITY_BITS_DEF = 16;

	typedef enum logic {
		OP_ENQUEUE = 1'b0,
		OP_DEQUEUE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_ENQUEUED = 2'd0,
		ST_DEQUEUED = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		op_t                operation;
		logic [15:0]        payload;
		logic signed [15:0] priority_req;
	} req_word_t;

	typedef struct packed {
		status_t            status;
		logic [15:0]        out_payload;
		logic signed [15:0] out_priority;
		logic [4:0]         occupancy;
		logic               is_empty;
	} rsp_word_t;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic enq;
		logic deq;
	} cell_ctrl_t;

endpackage : spq_pkg
`default_nettype wire

// ===== src/spq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds, shifts down on insert, shifts up on pop
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
#(
	parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEF,
	parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire cell_ctrl_t                 ctrl,
	input  wire logic signed [PRIORITY_BITS-1:0] new_pri,
	input  wire logic [PAYLOAD_BITS-1:0]    new_pay,
	// neighbour towards the front
	input  wire logic                       left_valid,
	input  wire logic                       left_stays,
	input  wire logic signed [PRIORITY_BITS-1:0] left_pri,
	input  wire logic [PAYLOAD_BITS-1:0]    left_pay,
	// neighbour towards the back
	input  wire logic                       right_valid,
	input  wire logic signed [PRIORITY_BITS-1:0] right_pri,
	input  wire logic [PAYLOAD_BITS-1:0]    right_pay,
	output logic                            valid,
	output logic                            stays,
	output logic signed [PRIORITY_BITS-1:0] pri,
	output logic [PAYLOAD_BITS-1:0]         pay
);

	logic                            valid_q;
	logic signed [PRIORITY_BITS-1:0] pri_q;
	logic [PAYLOAD_BITS-1:0]         pay_q;
	logic                            valid_d;
	logic signed [PRIORITY_BITS-1:0] pri_d;
	logic [PAYLOAD_BITS-1:0]         pay_d;

	// equal or higher priority keeps its place ahead of the new entry
	assign stays = valid_q && (pri_q >= new_pri);

	always_comb begin
		valid_d = valid_q;
		pri_d   = pri_q;
		pay_d   = pay_q;
		if (ctrl.enq) begin
			valid_d = valid_q | left_valid;
			if (!stays) begin
				if (left_stays) begin
					pri_d = new_pri;
					pay_d = new_pay;
				end else begin
					pri_d = left_pri;
					pay_d = left_pay;
				end
			end
		end else if (ctrl.deq) begin
			valid_d = right_valid;
			pri_d   = right_pri;
			pay_d   = right_pay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		pri_q <= pri_d;
		pay_q <= pay_d;
	end

	assign valid = valid_q;
	assign pri   = pri_q;
	assign pay   = pay_q;

endmodule : spq_cell
`default_nettype wire

// ===== src/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// fixed-depth priority queue built as a chain of sorting cells
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid / req_ready / req) carries one command word:
//   enqueue of a payload with a signed priority, or dequeue of the front.
//   rsp channel (rsp_valid / rsp_ready / rsp) returns exactly one word per
//   command: status, dequeued payload and priority, occupancy, empty flag.
//   every cell compares against the broadcast priority and shifts at once,
//   so one command completes in the cycle it is accepted; the response
//   word appears in the output register in the cycle after acceptance.
//   throughput is one command per cycle while rsp_ready is high.
//   equal priorities leave in arrival order; an enqueue on a full queue
//   answers full and drops the entry, a dequeue on an empty one answers
//   empty, neither touches the stored entries.
//   reset clears every cell's valid flag and the entry count; no clearing
//   pass is needed. while rsp_ready is low the held response stays put and
//   req_ready drops until that word has been taken.
// ----------------------------------------------------------------------------
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
	parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEF,
	parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire req_word_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output rsp_word_t      rsp
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// chain signals, one per cell
	logic                            cell_valid [QUEUE_DEPTH];
	logic                            cell_stays [QUEUE_DEPTH];
	logic signed [PRIORITY_BITS-1:0] cell_pri   [QUEUE_DEPTH];
	logic [PAYLOAD_BITS-1:0]         cell_pay   [QUEUE_DEPTH];

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          rsp_valid_q;
	rsp_word_t     rsp_q;
	rsp_word_t     rsp_d;

	logic       accept;
	logic       full;
	logic       empty;
	cell_ctrl_t ctrl;

	logic [63:0]                     pay_in_wide;
	logic [63:0]                     pri_in_wide;
	logic [PAYLOAD_BITS-1:0]         new_pay;
	logic signed [PRIORITY_BITS-1:0] new_pri;
	logic [63:0]                     pay_out_wide;
	logic [63:0]                     pri_out_wide;
	logic [63:0]                     count_wide;

	// output register frees up when empty or being drained this cycle
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	assign full  = cell_valid[QUEUE_DEPTH-1];
	assign empty = !cell_valid[0];

	assign ctrl.enq = accept && (req.operation == OP_ENQUEUE) && !full;
	assign ctrl.deq = accept && (req.operation == OP_DEQUEUE) && !empty;

	// fit the fixed-width fields to the stored widths
	assign pay_in_wide = 64'(req.payload);
	assign pri_in_wide = 64'($unsigned(req.priority_req));
	assign new_pay     = pay_in_wide[PAYLOAD_BITS-1:0];
	assign new_pri     = $signed(pri_in_wide[PRIORITY_BITS-1:0]);

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			logic                            l_valid;
			logic                            l_stays;
			logic signed [PRIORITY_BITS-1:0] l_pri;
			logic [PAYLOAD_BITS-1:0]         l_pay;
			logic                            r_valid;
			logic signed [PRIORITY_BITS-1:0] r_pri;
			logic [PAYLOAD_BITS-1:0]         r_pay;

			if (gi == 0) begin : g_head
				// front cell sees a full, staying neighbour ahead of it
				assign l_valid = 1'b1;
				assign l_stays = 1'b1;
				assign l_pri   = '0;
				assign l_pay   = '0;
			end else begin : g_link_l
				assign l_valid = cell_valid[gi-1];
				assign l_stays = cell_stays[gi-1];
				assign l_pri   = cell_pri[gi-1];
				assign l_pay   = cell_pay[gi-1];
			end

			if (gi == QUEUE_DEPTH - 1) begin : g_tail
				assign r_valid = 1'b0;
				assign r_pri   = '0;
				assign r_pay   = '0;
			end else begin : g_link_r
				assign r_valid = cell_valid[gi+1];
				assign r_pri   = cell_pri[gi+1];
				assign r_pay   = cell_pay[gi+1];
			end

			spq_cell #(
				.PAYLOAD_BITS  (PAYLOAD_BITS),
				.PRIORITY_BITS (PRIORITY_BITS)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.new_pri     (new_pri),
				.new_pay     (new_pay),
				.left_valid  (l_valid),
				.left_stays  (l_stays),
				.left_pri    (l_pri),
				.left_pay    (l_pay),
				.right_valid (r_valid),
				.right_pri   (r_pri),
				.right_pay   (r_pay),
				.valid       (cell_valid[gi]),
				.stays       (cell_stays[gi]),
				.pri         (cell_pri[gi]),
				.pay         (cell_pay[gi])
			);
		end
	endgenerate

	// entry count after this command
	always_comb begin
		count_d = count_q;
		if (ctrl.enq) begin
			count_d = count_q + CW'(1);
		end else if (ctrl.deq) begin
			count_d = count_q - CW'(1);
		end
	end

	// front entry, reported as raw bits of the stored width
	assign pay_out_wide = 64'(cell_pay[0]);
	assign pri_out_wide = 64'($unsigned(cell_pri[0]));
	assign count_wide   = 64'(count_d);

	always_comb begin
		rsp_d              = '0;
		rsp_d.occupancy    = count_wide[4:0];
		rsp_d.is_empty     = (count_d == '0);
		case (req.operation)
			OP_ENQUEUE: begin
				rsp_d.status = full ? ST_FULL : ST_ENQUEUED;
			end
			OP_DEQUEUE: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					rsp_d.status       = ST_DEQUEUED;
					rsp_d.out_payload  = pay_out_wide[15:0];
					rsp_d.out_priority = $signed(pri_out_wide[15:0]);
				end
			end
			default: begin
				rsp_d.status = ST_EMPTY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response word held until taken
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule : sorted_priority_queue
`default_nettype wire
